### sv/plr_pkg.sv
package plr_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned ColorW   = 16;
  localparam int unsigned LineW    = 16;
  localparam int unsigned CoordW   = 10;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned PaletteDepth = 1 << CodeW;

  localparam logic [ModeW-1:0] DisposalRestoreBg = ModeW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    CfgFrameX       = 3'd0,
    CfgFrameWidth   = 3'd1,
    CfgTransparent  = 3'd2,
    CfgBackground   = 3'd3,
    CfgDisposal     = 3'd4,
    CfgTransparency = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [LineW-1:0] frame_x;
    logic [LineW-1:0] frame_width;
    logic [CodeW-1:0] transparent_code;
    logic [CodeW-1:0] background_code;
    logic [ModeW-1:0] disposal_mode;
    logic             transparency_on;
  } cfg_t;

  typedef struct packed {
    logic              draw;
    logic [CoordW-1:0] screen_x;
    logic [CoordW-1:0] screen_y;
    logic              segment_start;
    logic [CodeW-1:0]  code;
  } pix_t;

endpackage

### sv/plr_if.sv
interface plr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [plr_pkg::CodeW-1:0]    code;
  logic [plr_pkg::ColorW-1:0]   color;
  logic [plr_pkg::LineW-1:0]    line_y;
  logic                         line_start;

  modport source (output valid, kind, code, color, line_y, line_start, input ready);
  modport sink   (input valid, kind, code, color, line_y, line_start, output ready);
endinterface

interface plr_out_if;
  logic                         valid;
  logic                         ready;
  logic [plr_pkg::CoordW-1:0]   screen_x;
  logic [plr_pkg::CoordW-1:0]   screen_y;
  logic [plr_pkg::ColorW-1:0]   pixel_color;
  logic                         segment_start;

  modport source (output valid, screen_x, screen_y, pixel_color, segment_start, input ready);
  modport sink   (input valid, screen_x, screen_y, pixel_color, segment_start, output ready);
endinterface

### sv/plr_cfg_regs.sv
module plr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [plr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [plr_pkg::CfgDataW-1:0]   cfg_data_i,
  output plr_pkg::cfg_t                  cfg_o
);

  plr_pkg::cfg_t cfg_q;
  plr_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        plr_pkg::CfgFrameX:       cfg_d.frame_x          = cfg_data_i;
        plr_pkg::CfgFrameWidth:   cfg_d.frame_width      = cfg_data_i;
        plr_pkg::CfgTransparent:  cfg_d.transparent_code = cfg_data_i[plr_pkg::CodeW-1:0];
        plr_pkg::CfgBackground:   cfg_d.background_code  = cfg_data_i[plr_pkg::CodeW-1:0];
        plr_pkg::CfgDisposal:     cfg_d.disposal_mode    = cfg_data_i[plr_pkg::ModeW-1:0];
        plr_pkg::CfgTransparency: cfg_d.transparency_on  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/plr_line_ctrl.sv
module plr_line_ctrl #(
  parameter int unsigned DISPLAY_COLUMNS = 320,
  parameter int unsigned DISPLAY_ROWS    = 240,
  parameter int unsigned SEGMENT_LENGTH  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pixel_acc_i,
  input  logic [plr_pkg::CodeW-1:0]     code_i,
  input  logic [plr_pkg::LineW-1:0]     line_y_i,
  input  logic                          line_start_i,
  input  plr_pkg::cfg_t                 cfg_i,
  output plr_pkg::pix_t                 pix_o
);

  localparam int unsigned RunW = $clog2(SEGMENT_LENGTH + 1);
  localparam int unsigned PosW = plr_pkg::LineW;

  logic [PosW-1:0] line_pos_q, line_pos_d;
  logic [RunW-1:0] run_q, run_d;
  logic            prev_q, prev_d;

  logic [PosW-1:0] pos_base;
  logic [RunW-1:0] run_base;
  logic            prev_base;
  logic [PosW:0]   pos_sum;
  logic            drawn;
  logic            mode_bg;
  logic            match;
  logic            hidden;
  logic            seg;
  logic [plr_pkg::CodeW-1:0] sub_code;

  always_comb begin
    pos_base  = line_start_i ? '0 : line_pos_q;
    run_base  = line_start_i ? '0 : run_q;
    prev_base = line_start_i ? 1'b0 : prev_q;
    pos_sum   = {1'b0, cfg_i.frame_x} + {1'b0, pos_base};
    drawn     = (line_y_i < PosW'(DISPLAY_ROWS)) &&
                (cfg_i.frame_x < PosW'(DISPLAY_COLUMNS)) &&
                (pos_base < cfg_i.frame_width) &&
                (pos_sum < (PosW + 1)'(DISPLAY_COLUMNS));
    mode_bg   = (cfg_i.disposal_mode == plr_pkg::DisposalRestoreBg);
    match     = (code_i == cfg_i.transparent_code);
    sub_code  = (mode_bg && match) ? cfg_i.background_code : code_i;
    hidden    = cfg_i.transparency_on && !mode_bg && match;
    seg       = !prev_base || (run_base >= RunW'(SEGMENT_LENGTH));

    line_pos_d = line_pos_q;
    run_d      = run_q;
    prev_d     = prev_q;
    if (pixel_acc_i) begin
      line_pos_d = (pos_base == '1) ? pos_base : pos_base + PosW'(1);
      run_d      = run_base;
      prev_d     = prev_base;
      if (drawn) begin
        if (hidden) begin
          run_d  = '0;
          prev_d = 1'b0;
        end else begin
          run_d  = seg ? RunW'(1) : run_base + RunW'(1);
          prev_d = 1'b1;
        end
      end
    end

    pix_o.draw          = drawn && !hidden;
    pix_o.screen_x      = pos_sum[plr_pkg::CoordW-1:0];
    pix_o.screen_y      = line_y_i[plr_pkg::CoordW-1:0];
    pix_o.segment_start = seg;
    pix_o.code          = sub_code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pos_q <= '0;
      run_q      <= '0;
      prev_q     <= 1'b0;
    end else begin
      line_pos_q <= line_pos_d;
      run_q      <= run_d;
      prev_q     <= prev_d;
    end
  end

endmodule

### sv/plr_palette.sv
module plr_palette (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [plr_pkg::CodeW-1:0]     wr_addr_i,
  input  logic [plr_pkg::ColorW-1:0]    wr_data_i,
  input  logic                          rd_en_i,
  input  logic [plr_pkg::CodeW-1:0]     rd_addr_i,
  output logic [plr_pkg::ColorW-1:0]    rd_data_o
);

  logic [plr_pkg::ColorW-1:0] mem_q [plr_pkg::PaletteDepth];
  logic [plr_pkg::ColorW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/palette_line_renderer_unit.sv
// Channel   Direction  Payload
// in_ch_i   sink       kind, code, color, line_y, line_start
// out_ch_o  source     screen_x, screen_y, pixel_color, segment_start
//
// One item is accepted per clock while the output is free; a drawn pixel
// appears in the cycle after it is accepted, from the registered palette read.
// Palette writes and cropped or transparent pixels produce no output item.
// Reset clears the configuration registers and the line state; the palette
// holds no reset and must be written before it is read.
// While the output register holds an item that is not taken, the input stalls.
module palette_line_renderer_unit #(
  parameter int unsigned DISPLAY_COLUMNS = 320,
  parameter int unsigned DISPLAY_ROWS    = 240,
  parameter int unsigned SEGMENT_LENGTH  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  plr_in_if.sink                        in_ch_i,
  plr_out_if.source                     out_ch_o,
  input  logic                          cfg_we_i,
  input  logic [plr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [plr_pkg::CfgDataW-1:0]  cfg_data_i
);

  plr_pkg::cfg_t cfg;
  plr_pkg::pix_t pix;

  logic in_ready;
  logic in_acc;
  logic pixel_acc;
  logic write_acc;

  logic                        out_valid_q, out_valid_d;
  logic [plr_pkg::CoordW-1:0]  screen_x_q;
  logic [plr_pkg::CoordW-1:0]  screen_y_q;
  logic                        seg_q;

  assign in_ready  = !out_valid_q || out_ch_o.ready;
  assign in_acc    = in_ch_i.valid && in_ready;
  assign pixel_acc = in_acc && in_ch_i.kind;
  assign write_acc = in_acc && !in_ch_i.kind;

  plr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  plr_line_ctrl #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_ROWS    (DISPLAY_ROWS),
    .SEGMENT_LENGTH  (SEGMENT_LENGTH)
  ) u_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pixel_acc_i  (pixel_acc),
    .code_i       (in_ch_i.code),
    .line_y_i     (in_ch_i.line_y),
    .line_start_i (in_ch_i.line_start),
    .cfg_i        (cfg),
    .pix_o        (pix)
  );

  plr_palette u_palette (
    .clk_i     (clk_i),
    .wr_en_i   (write_acc),
    .wr_addr_i (in_ch_i.code),
    .wr_data_i (in_ch_i.color),
    .rd_en_i   (pixel_acc),
    .rd_addr_i (pix.code),
    .rd_data_o (out_ch_o.pixel_color)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_ready) begin
      out_valid_d = pixel_acc && pix.draw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pixel_acc) begin
      screen_x_q <= pix.screen_x;
      screen_y_q <= pix.screen_y;
      seg_q      <= pix.segment_start;
    end
  end

  assign in_ch_i.ready          = in_ready;
  assign out_ch_o.valid         = out_valid_q;
  assign out_ch_o.screen_x      = screen_x_q;
  assign out_ch_o.screen_y      = screen_y_q;
  assign out_ch_o.segment_start = seg_q;

endmodule

### sv/plr_checker.sv
module plr_checker #(
  parameter int unsigned DISPLAY_COLUMNS = 320,
  parameter int unsigned DISPLAY_ROWS    = 240
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_kind_i,
  input logic                          in_line_start_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [plr_pkg::CoordW-1:0]    out_screen_x_i,
  input logic [plr_pkg::CoordW-1:0]    out_screen_y_i,
  input logic [plr_pkg::ColorW-1:0]    out_pixel_color_i,
  input logic                          out_segment_start_i
);

  logic in_acc;
  logic out_free;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_free = !out_valid_i || out_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_screen_x_i) && $stable(out_screen_y_i) &&
      $stable(out_pixel_color_i) && $stable(out_segment_start_i))
    else $error("output payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_kind_i && out_free |=> !out_valid_i)
    else $error("palette write produced an output item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(out_screen_x_i) < DISPLAY_COLUMNS) &&
      (32'(out_screen_y_i) < DISPLAY_ROWS))
    else $error("output pixel lies outside the display");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_kind_i && in_line_start_i && out_free |=> !out_valid_i || out_segment_start_i)
    else $error("first pixel of a line did not start a segment");

endmodule

bind palette_line_renderer_unit plr_checker #(
  .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
  .DISPLAY_ROWS    (DISPLAY_ROWS)
) u_plr_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_ch_i.valid),
  .in_ready_i          (in_ch_i.ready),
  .in_kind_i           (in_ch_i.kind),
  .in_line_start_i     (in_ch_i.line_start),
  .out_valid_i         (out_ch_o.valid),
  .out_ready_i         (out_ch_o.ready),
  .out_screen_x_i      (out_ch_o.screen_x),
  .out_screen_y_i      (out_ch_o.screen_y),
  .out_pixel_color_i   (out_ch_o.pixel_color),
  .out_segment_start_i (out_ch_o.segment_start)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int DisplayColumns = 320;
  localparam int DisplayRows    = 240;
  localparam int SegmentLength  = 256;

  localparam logic KindPalette = 1'b0;
  localparam logic KindPixel   = 1'b1;

  typedef struct {
    logic [plr_pkg::CoordW-1:0] screen_x;
    logic [plr_pkg::CoordW-1:0] screen_y;
    logic [plr_pkg::ColorW-1:0] pixel_color;
    logic                       segment_start;
  } drawn_pixel_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we;
  plr_pkg::cfg_idx_e            cfg_index;
  logic [plr_pkg::CfgDataW-1:0] cfg_data;

  plr_in_if  in_ch ();
  plr_out_if out_ch ();

  palette_line_renderer_unit #(
    .DISPLAY_COLUMNS(DisplayColumns),
    .DISPLAY_ROWS   (DisplayRows),
    .SEGMENT_LENGTH (SegmentLength)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch_i    (in_ch),
    .out_ch_o   (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  plr_pkg::cfg_t              frame;
  logic [plr_pkg::ColorW-1:0] palette_copy [plr_pkg::PaletteDepth];
  logic [plr_pkg::LineW-1:0]  line_pos;
  int                         run_len;
  bit                         prev_opaque;
  drawn_pixel_t               pixels_due [$];

  int fail_count = 0;
  bit tx_steady  = 1'b0;
  bit rx_steady  = 1'b0;

  always #10 clk_i = ~clk_i;

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic void render_item(logic kind, logic [plr_pkg::CodeW-1:0] code,
                                      logic [plr_pkg::ColorW-1:0] color,
                                      logic [plr_pkg::LineW-1:0] y, logic start);
    int                        width;
    logic [plr_pkg::LineW-1:0] pos;
    logic [plr_pkg::CodeW-1:0] shown;
    bit                        keyed;
    bit                        seg;
    drawn_pixel_t              px;
    if (kind == KindPalette) begin
      palette_copy[code] = color;
      return;
    end
    if (start) begin
      line_pos    = '0;
      run_len     = 0;
      prev_opaque = 1'b0;
    end
    pos = line_pos;
    if (line_pos != '1) line_pos++;
    width = int'(frame.frame_width);
    if (width + int'(frame.frame_x) > DisplayColumns) begin
      width = DisplayColumns - int'(frame.frame_x);
    end
    if (int'(y) >= DisplayRows || int'(frame.frame_x) >= DisplayColumns || width < 1 ||
        int'(pos) >= width) begin
      return;
    end
    shown = code;
    keyed = frame.transparency_on;
    if (frame.disposal_mode == plr_pkg::DisposalRestoreBg) begin
      if (shown == frame.transparent_code) shown = frame.background_code;
      keyed = 1'b0;
    end
    if (keyed && shown == frame.transparent_code) begin
      prev_opaque = 1'b0;
      run_len     = 0;
      return;
    end
    seg         = !prev_opaque || run_len >= SegmentLength;
    run_len     = seg ? 1 : run_len + 1;
    prev_opaque = 1'b1;
    px.screen_x      = plr_pkg::CoordW'(frame.frame_x + pos);
    px.screen_y      = y[plr_pkg::CoordW-1:0];
    px.pixel_color   = palette_copy[shown];
    px.segment_start = seg;
    pixels_due = {pixels_due, px};
  endfunction

  task automatic send_item(input logic kind, input logic [plr_pkg::CodeW-1:0] code,
                           input logic [plr_pkg::ColorW-1:0] color,
                           input logic [plr_pkg::LineW-1:0] y, input logic start);
    int gap;
    gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : gap_length();
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid      = 1'b1;
    in_ch.kind       = kind;
    in_ch.code       = code;
    in_ch.color      = color;
    in_ch.line_y     = y;
    in_ch.line_start = start;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    render_item(kind, code, color, y, start);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input plr_pkg::cfg_idx_e idx,
                           input logic [plr_pkg::CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      plr_pkg::CfgFrameX:       frame.frame_x = value;
      plr_pkg::CfgFrameWidth:   frame.frame_width = value;
      plr_pkg::CfgTransparent:  frame.transparent_code = value[plr_pkg::CodeW-1:0];
      plr_pkg::CfgBackground:   frame.background_code = value[plr_pkg::CodeW-1:0];
      plr_pkg::CfgDisposal:     frame.disposal_mode = value[plr_pkg::ModeW-1:0];
      plr_pkg::CfgTransparency: frame.transparency_on = value[0];
      default: ;
    endcase
  endtask

  task automatic load_frame(input logic [plr_pkg::CfgDataW-1:0] fx,
                            input logic [plr_pkg::CfgDataW-1:0] fw,
                            input logic [plr_pkg::CfgDataW-1:0] tc,
                            input logic [plr_pkg::CfgDataW-1:0] bc,
                            input logic [plr_pkg::CfgDataW-1:0] mode,
                            input logic [plr_pkg::CfgDataW-1:0] ton);
    wait_idle();
    cfg_write(plr_pkg::CfgFrameX, fx);
    cfg_write(plr_pkg::CfgFrameWidth, fw);
    cfg_write(plr_pkg::CfgTransparent, tc);
    cfg_write(plr_pkg::CfgBackground, bc);
    cfg_write(plr_pkg::CfgDisposal, mode);
    cfg_write(plr_pkg::CfgTransparency, ton);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic test_palette_fill();
    logic [plr_pkg::ColorW-1:0] color;
    for (int c = 0; c < plr_pkg::PaletteDepth; c++) begin
      color = (c == 0) ? 16'h0000 : (c == plr_pkg::PaletteDepth - 1) ? 16'hFFFF :
              16'($urandom);
      send_item(KindPalette, plr_pkg::CodeW'(c), color, 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_transparency();
    logic [plr_pkg::CodeW-1:0] codes [9];
    codes = '{8'h10, 8'h20, 8'h21, 8'h10, 8'h10, 8'hFF, 8'h00, 8'h00, 8'h01};
    load_frame(16'd0, 16'd8, 16'h0010, 16'h00FF, 16'd0, 16'd1);
    for (int k = 0; k < 9; k++) begin
      send_item(KindPixel, codes[k], 16'($urandom), 16'd0, k == 0);
      if (k == 5) send_item(KindPalette, 8'h00, 16'h0000, 16'hFFFF, 1'b1);
    end
    send_item(KindPixel, 8'hFF, 16'hFFFF, 16'd239, 1'b1);
    send_item(KindPixel, 8'h20, 16'h0000, 16'd240, 1'b1);
    send_item(KindPixel, 8'h20, 16'h0000, 16'hFFFF, 1'b1);
  endtask

  task automatic test_disposal_crop();
    load_frame(16'd310, 16'd20, 16'h0010, 16'h00FF, 16'(plr_pkg::DisposalRestoreBg), 16'd1);
    for (int k = 0; k < 11; k++) begin
      send_item(KindPixel, k[0] ? 8'h10 : 8'(8'h40 + k), 16'($urandom), 16'd100, k == 0);
    end
  endtask

  task automatic test_dropped();
    load_frame(16'hFFFF, 16'hFFFF, 16'h00FF, 16'h0000, 16'd7, 16'hFFFF);
    for (int k = 0; k < 3; k++) send_item(KindPixel, 8'h33, 16'($urandom), 16'd1, k == 0);
    load_frame(16'd0, 16'd0, 16'hFF00, 16'hFFFF, 16'd0, 16'hFFFE);
    for (int k = 0; k < 2; k++) send_item(KindPixel, 8'h34, 16'($urandom), 16'd2, k == 0);
  endtask

  task automatic test_segment_length();
    load_frame(16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
    for (int k = 0; k < 300; k++) begin
      send_item(KindPixel, 8'($urandom), 16'($urandom), 16'd17, k == 0);
    end
  endtask

  task automatic test_back_to_back();
    load_frame(16'd280, 16'd320, 16'd0, 16'd0, 16'd0, 16'd0);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int k = 0; k < 60; k++) begin
      send_item(KindPixel, 8'($urandom), 16'($urandom), 16'd239, k == 0);
    end
    send_item(KindPixel, 8'($urandom), 16'($urandom), 16'd0, 1'b1);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_lines();
    int                        sent;
    int                        row;
    int                        len;
    int                        lines;
    logic [plr_pkg::LineW-1:0] y;
    logic [plr_pkg::LineW-1:0] fx;
    logic [plr_pkg::LineW-1:0] fw;
    logic [plr_pkg::CodeW-1:0] code;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0:       fx = 16'hFFFF;
        1:       fx = 16'($urandom_range(300, 330));
        2:       fx = 16'($urandom);
        3:       fx = 16'd0;
        default: fx = 16'($urandom_range(0, 200));
      endcase
      case ($urandom_range(0, 9))
        0:       fw = 16'd0;
        1:       fw = 16'hFFFF;
        2:       fw = 16'($urandom_range(257, 320));
        default: fw = 16'($urandom_range(1, 40));
      endcase
      load_frame(fx, fw, 16'($urandom), 16'($urandom),
                 ($urandom_range(0, 2) == 0) ? 16'(plr_pkg::DisposalRestoreBg) :
                 16'($urandom), 16'($urandom));
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      row   = $urandom_range(0, DisplayRows - 1);
      sent  = 0;
      lines = 0;
      while (sent < 35) begin
        if (phase == 6 && lines == 1) wait_idle();
        y   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(row);
        row = (row + 1) % DisplayRows;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 330) : $urandom_range(1, 48);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_item(KindPalette, 8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
            sent++;
          end
          code = ($urandom_range(0, 2) == 0) ? frame.transparent_code : 8'($urandom);
          send_item(KindPixel, code, 16'($urandom), y,
                    (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 29) == 0));
          sent++;
        end
        lines++;
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    int hold;
    out_ch.ready = 1'b0;
    forever begin
      if (!rx_steady && $urandom_range(0, 3) == 0) begin
        hold = gap_length();
        repeat (hold) begin
          @(negedge clk_i);
          out_ch.ready = 1'b0;
        end
      end
      @(negedge clk_i);
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    drawn_pixel_t want;
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pixels_due.size() == 0) begin
        $error("pixel with no pending expectation: x %0d y %0d", out_ch.screen_x,
               out_ch.screen_y);
        fail_count++;
      end else begin
        want = pixels_due.pop_front();
        if (out_ch.screen_x !== want.screen_x) begin
          $error("screen_x: expected %0d, got %0d", want.screen_x, out_ch.screen_x);
          fail_count++;
        end
        if (out_ch.screen_y !== want.screen_y) begin
          $error("screen_y: expected %0d, got %0d", want.screen_y, out_ch.screen_y);
          fail_count++;
        end
        if (out_ch.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %h, got %h", want.pixel_color, out_ch.pixel_color);
          fail_count++;
        end
        if (out_ch.segment_start !== want.segment_start) begin
          $error("segment_start: expected %0d, got %0d", want.segment_start,
                 out_ch.segment_start);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = plr_pkg::CfgFrameX;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KindPalette;
    in_ch.code       = '0;
    in_ch.color      = '0;
    in_ch.line_y     = '0;
    in_ch.line_start = 1'b0;
    frame            = '0;
    line_pos         = '0;
    run_len          = 0;
    prev_opaque      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_palette_fill();
    test_transparency();
    test_disposal_crop();
    test_dropped();
    test_segment_length();
    test_back_to_back();
    test_random_lines();
    wait_idle();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
sv/plr_pkg.sv
sv/plr_if.sv
sv/plr_cfg_regs.sv
sv/plr_line_ctrl.sv
sv/plr_palette.sv
sv/palette_line_renderer_unit.sv
sv/plr_checker.sv
tb/sv/tb.sv
